// File: sv/usd_pkg.sv
// ----------------------------------------------------------------------------
// usd_pkg
// Shared types for the unsigned shift-subtract divider: controller commands
// and datapath status.
// ----------------------------------------------------------------------------
package usd_pkg;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;   // capture operands, clear partial remainder
      logic step;   // one restoring-division iteration
      logic store;  // move the finished result into the output register
   } usd_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic divisor_zero;  // divisor on the request channel is zero
   } usd_status_type;

endpackage

// File: sv/usd_if.sv
// ----------------------------------------------------------------------------
// usd_if
// Valid/ready channels of the divider: request (operands) and response
// (quotient, remainder, divide-by-zero flag).
// ----------------------------------------------------------------------------
interface usd_req_if #(
   parameter int WIDTH = 32
) ();
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] dividend;
   logic [WIDTH-1:0] divisor;

   modport source (output valid, output dividend, output divisor, input ready);
   modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

interface usd_rsp_if #(
   parameter int WIDTH = 32
) ();
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] quotient;
   logic [WIDTH-1:0] remainder;
   logic             divide_by_zero;

   modport source (output valid, output quotient, output remainder,
                   output divide_by_zero, input ready);
   modport sink   (input valid, input quotient, input remainder,
                   input divide_by_zero, output ready);
endinterface

// File: sv/usd_ctrl.sv
// ----------------------------------------------------------------------------
// usd_ctrl
// Sequencer of the divider: accepts a request beat, runs one iteration per
// cycle, and hands the result to the output register when it is free.
// ----------------------------------------------------------------------------
module usd_ctrl #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   input  usd_pkg::usd_status_type status,
   output usd_pkg::usd_cmd_type    cmd
);
   import usd_pkg::*;

   localparam int CNT_W = $clog2(DATA_WIDTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      req_ready = 1'b0;
      cmd       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               count_in = '0;
               state_in = status.divisor_zero ? ST_DRAIN : ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.step = 1'b1;
            count_in = count_ff + 1'b1;
            if (count_ff == CNT_W'(DATA_WIDTH - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (slot_free) begin
               cmd.store = 1'b1;
               req_ready = 1'b1;
               // next operands may load in the same cycle the result leaves
               if (req_valid) begin
                  cmd.load = 1'b1;
                  count_in = '0;
                  state_in = status.divisor_zero ? ST_DRAIN : ST_RUN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (cmd.store) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: sv/usd_dpath.sv
// ----------------------------------------------------------------------------
// usd_dpath
// Restoring-division datapath: partial remainder, quotient/dividend shift
// register, divisor, one subtract-and-compare per step, output register.
// ----------------------------------------------------------------------------
module usd_dpath #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                    clock,
   input  usd_pkg::usd_cmd_type    cmd,
   output usd_pkg::usd_status_type status,
   input  logic [DATA_WIDTH-1:0]   dividend,
   input  logic [DATA_WIDTH-1:0]   divisor,
   output logic [DATA_WIDTH-1:0]   quotient,
   output logic [DATA_WIDTH-1:0]   remainder,
   output logic                    divide_by_zero
);
   import usd_pkg::*;

   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] quo_ff, quo_in;   // dividend bits shift out, quotient in
   logic [DATA_WIDTH-1:0] den_ff;
   logic                  zero_ff;
   logic [DATA_WIDTH-1:0] q_out_ff, r_out_ff;
   logic                  dbz_out_ff;

   logic                  carry;
   logic [DATA_WIDTH-1:0] shifted;
   logic [DATA_WIDTH-1:0] diff;
   logic                  fits;

   assign status.divisor_zero = (divisor == '0);

   // carry is the bit shifted out of the remainder: divisor always fits then
   assign carry   = rem_ff[DATA_WIDTH-1];
   assign shifted = {rem_ff[DATA_WIDTH-2:0], quo_ff[DATA_WIDTH-1]};
   assign diff    = shifted - den_ff;
   assign fits    = carry || (shifted >= den_ff);

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (cmd.load) begin
         rem_in = '0;
         quo_in = dividend;
      end else if (cmd.step) begin
         rem_in = fits ? diff : shifted;
         quo_in = {quo_ff[DATA_WIDTH-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (cmd.load) begin
         den_ff  <= divisor;
         zero_ff <= (divisor == '0);
      end
      if (cmd.store) begin
         // zero divisor: no steps ran, quo_ff still holds the dividend
         q_out_ff   <= zero_ff ? '0 : quo_ff;
         r_out_ff   <= zero_ff ? quo_ff : rem_ff;
         dbz_out_ff <= zero_ff;
      end
   end

   assign quotient       = q_out_ff;
   assign remainder      = r_out_ff;
   assign divide_by_zero = dbz_out_ff;

endmodule

// File: sv/unsigned_shift_subtract_divider_unit.sv
// ----------------------------------------------------------------------------
// unsigned_shift_subtract_divider_unit
// Iteration: one quotient bit per cycle through the shared subtractor; a zero
//   divisor skips the iterations and goes straight to the drain state.
// Back-to-back: a new request is taken only after the last result is through;
//   it loads in the cycle that result enters the free output register.
// Reset: synchronous, active high; clears sequencer and response valid only.
// ----------------------------------------------------------------------------
module unsigned_shift_subtract_divider_unit #(
   parameter int DATA_WIDTH = 32
) (
   input logic       clock,
   input logic       reset,
   usd_req_if.sink   req_bus,
   usd_rsp_if.source rsp_bus
);
   import usd_pkg::*;

   usd_cmd_type    cmd;
   usd_status_type status;

   // Sequencer: request accept, iteration count, response valid.
   usd_ctrl #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: operand capture, shift-subtract step, result register.
   usd_dpath #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock          (clock),
      .cmd            (cmd),
      .status         (status),
      .dividend       (req_bus.dividend),
      .divisor        (req_bus.divisor),
      .quotient       (rsp_bus.quotient),
      .remainder      (rsp_bus.remainder),
      .divide_by_zero (rsp_bus.divide_by_zero)
   );

endmodule

// File: sv/usd_checker.sv
// ----------------------------------------------------------------------------
// usd_checker
// Port-level checks of the divider, bound to the top level.
// ----------------------------------------------------------------------------
module usd_checker #(
   parameter int DATA_WIDTH = 32
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic [DATA_WIDTH-1:0] req_divisor,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [DATA_WIDTH-1:0] rsp_quotient,
   input logic                  rsp_divide_by_zero
);

   // response beat held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_quotient))
      else $error("response dropped or changed while stalled");

   // a nonzero divisor keeps the unit busy on the following cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_divisor != '0) |=> !req_ready)
      else $error("request accepted during iteration");

   // zero-divisor results carry a zero quotient
   a_dbz_quotient: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_by_zero |-> rsp_quotient == '0)
      else $error("nonzero quotient on divide by zero");

   // no response right out of reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind unsigned_shift_subtract_divider_unit usd_checker #(
   .DATA_WIDTH (DATA_WIDTH)
) u_usd_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_bus.valid),
   .req_ready          (req_bus.ready),
   .req_divisor        (req_bus.divisor),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_quotient       (rsp_bus.quotient),
   .rsp_divide_by_zero (rsp_bus.divide_by_zero)
);
